// ===== hdl/bmr_pkg.sv =====
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types and constants for the bilinear map resampler.
// ----------------------------------------------------------------------------
package bmr_pkg;

  localparam int unsigned STORE_DEPTH_DEF   = 32768;
  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  localparam int unsigned CHANNELS_DEF      = 3;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned IDX_W  = 15;
  localparam int unsigned PT_W   = 11;
  localparam int unsigned SW_W   = 11;
  localparam int unsigned TW_W   = 12;
  localparam int unsigned CH_W   = 16;
  localparam int unsigned NCH    = 3;
  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_TGT_W = 2'd2;
  localparam logic [1:0] REG_TGT_H = 2'd3;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_INTERP = 1'b1;

  typedef enum logic [2:0] {
    SEL_A = 3'd0,
    SEL_B = 3'd1,
    SEL_D = 3'd2,
    SEL_E = 3'd3
  } nbr_sel_t;

  typedef struct packed {
    logic     store_wr;
    logic     load_op;
    logic     div_start;
    logic     div_y;
    logic     pos_calc;
    logic     rd_issue;
    nbr_sel_t rd_sel;
    logic     rd_capture;
    nbr_sel_t cap_sel;
    logic     blend_x;
    logic     blend_y;
    logic     blend_fin;
    logic     emit;
  } bmr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic geom_err;
  } bmr_stat_t;

endpackage

// ===== hdl/bmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmr_ctrl
// Sequencer: store, two divisions, four neighbour reads, three blend steps.
// ----------------------------------------------------------------------------
module bmr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              op,
  output logic              busy,
  output bmr_pkg::bmr_cmd_t cmd,
  input  bmr_pkg::bmr_stat_t stat
);
  import bmr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DIVX, S_DIVY, S_POS, S_RA, S_RB, S_RD, S_RE, S_CE,
    S_BX, S_BY, S_BF, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd_sel = SEL_A;
    cmd.cap_sel = SEL_A;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_op = 1'b1;
          if (op == OP_STORE) cmd.store_wr = 1'b1;
          else state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.geom_err) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_y = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_y = 1'b1;
        if (stat.div_done) state_nxt = S_POS;
      end
      S_POS: begin
        cmd.pos_calc = 1'b1;
        state_nxt = S_RA;
      end
      S_RA: begin
        cmd.rd_issue = 1'b1; cmd.rd_sel = SEL_A; state_nxt = S_RB;
      end
      S_RB: begin
        cmd.rd_issue = 1'b1; cmd.rd_sel = SEL_B;
        cmd.rd_capture = 1'b1; cmd.cap_sel = SEL_A; state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1; cmd.rd_sel = SEL_D;
        cmd.rd_capture = 1'b1; cmd.cap_sel = SEL_B; state_nxt = S_RE;
      end
      S_RE: begin
        cmd.rd_issue = 1'b1; cmd.rd_sel = SEL_E;
        cmd.rd_capture = 1'b1; cmd.cap_sel = SEL_D; state_nxt = S_CE;
      end
      S_CE: begin
        cmd.rd_capture = 1'b1; cmd.cap_sel = SEL_E; state_nxt = S_BX;
      end
      S_BX: begin
        cmd.blend_x = 1'b1; state_nxt = S_BY;
      end
      S_BY: begin
        cmd.blend_y = 1'b1; state_nxt = S_BF;
      end
      S_BF: begin
        cmd.blend_fin = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.emit = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== hdl/bmr_div.sv =====
// ----------------------------------------------------------------------------
// bmr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmr_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  assign quo = q_r;
  assign done = done_r;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

endmodule

// ===== hdl/bmr_dpath.sv =====
// ----------------------------------------------------------------------------
// bmr_dpath
// Source store, position divider, neighbour fetch and blend arithmetic.
// ----------------------------------------------------------------------------
module bmr_dpath #(
  parameter int unsigned STORE_DEPTH   = bmr_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = bmr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CHANNELS      = bmr_pkg::CHANNELS_DEF,
  parameter int unsigned FRACTION_BITS = bmr_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bmr_pkg::IDX_W-1:0]   sample_index,
  input  logic [bmr_pkg::PT_W-1:0]    point_x,
  input  logic [bmr_pkg::PT_W-1:0]    point_y,
  input  logic signed [bmr_pkg::CH_W-1:0] in_chan0,
  input  logic signed [bmr_pkg::CH_W-1:0] in_chan1,
  input  logic signed [bmr_pkg::CH_W-1:0] in_chan2,
  input  logic [bmr_pkg::SW_W-1:0]    src_w,
  input  logic [bmr_pkg::SW_W-1:0]    src_h,
  input  logic [bmr_pkg::TW_W-1:0]    tgt_w,
  input  logic [bmr_pkg::TW_W-1:0]    tgt_h,
  input  bmr_pkg::bmr_cmd_t           cmd,
  output bmr_pkg::bmr_stat_t          stat,
  output logic signed [bmr_pkg::CH_W-1:0] out_chan0,
  output logic signed [bmr_pkg::CH_W-1:0] out_chan1,
  output logic signed [bmr_pkg::CH_W-1:0] out_chan2,
  output logic                        out_status
);
  import bmr_pkg::*;

  localparam int unsigned AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned NW  = PT_W + SW_W + FB;
  localparam int unsigned PW  = SW_W + SW_W;
  localparam int unsigned T1W = SB + FB + 2;
  localparam int unsigned HW  = T1W - FB + 1;
  localparam int unsigned PRW = HW + FB + 2;
  localparam int unsigned ACW = PRW + 2;
  localparam logic [22:0] DEPTH_C = 23'(STORE_DEPTH);

  logic [SB-1:0] mem [STORE_DEPTH][CHANNELS];
  logic [SB-1:0] rd_r [CHANNELS];

  logic [PT_W-1:0]  pt_x_r, pt_y_r;
  logic             err_r;
  logic [SW_W-1:0]  x0_r, x1_r, y0_r, y1_r;
  logic [FB-1:0]    dx_r, dy_r;
  logic [NW-1:0]    qx_r;
  logic [AW-1:0]    rd_addr;
  logic [PW-1:0]    row0_r, row1_r;
  logic [SW_W-1:0]  xsel;
  logic [PW-1:0]    rowsel;
  logic [PW:0]      lin;

  logic signed [SB-1:0] nb_r [4][CHANNELS];
  logic signed [T1W-1:0] t1_r [CHANNELS];
  logic signed [T1W-1:0] t2_r [CHANNELS];
  logic signed [ACW-1:0] hi_r [CHANNELS];
  logic signed [ACW-1:0] lo_r [CHANNELS];
  logic signed [CH_W-1:0] res_r [NCH];

  logic [NW-1:0] div_num;
  logic [TW_W-1:0] div_den;
  logic [NW-1:0] quo;
  logic div_done;
  logic [PW-1:0] prod;

  assign prod = cmd.div_y ? PW'(pt_y_r) * PW'(src_h - 1'b1)
                          : PW'(pt_x_r) * PW'(src_w - 1'b1);
  assign div_num = NW'(prod) << FB;
  assign div_den = cmd.div_y ? (tgt_h - 1'b1) : (tgt_w - 1'b1);

  bmr_div #(.NW(NW), .DW(TW_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(div_num),
    .den(div_den), .quo(quo), .done(div_done)
  );

  logic [21:0] area;
  assign area = 22'(src_w) * 22'(src_h);
  assign stat.div_done = div_done;
  assign stat.geom_err = err_r;

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      pt_x_r <= point_x;
      pt_y_r <= point_y;
      err_r <= (src_w < 2) || (src_h < 2) || (tgt_w < 2) || (tgt_h < 2) ||
               ({1'b0, area} > DEPTH_C) ||
               ({1'b0, point_x} >= tgt_w) || ({1'b0, point_y} >= tgt_h);
    end
    if (div_done && cmd.div_start) qx_r <= quo;
  end

  function automatic logic [SW_W-1:0] lo_of(input logic [NW-1:0] q);
    lo_of = SW_W'(q >> FB);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.pos_calc) begin
      x0_r <= lo_of(qx_r);
      dx_r <= qx_r[FB-1:0];
      x1_r <= (lo_of(qx_r) + 1'b1 < src_w) ? lo_of(qx_r) + 1'b1 : src_w - 1'b1;
      y0_r <= lo_of(quo);
      dy_r <= quo[FB-1:0];
      y1_r <= (lo_of(quo) + 1'b1 < src_h) ? lo_of(quo) + 1'b1 : src_h - 1'b1;
      row0_r <= PW'(lo_of(quo)) * PW'(src_w);
      row1_r <= PW'((lo_of(quo) + 1'b1 < src_h) ? lo_of(quo) + 1'b1 : src_h - 1'b1)
                * PW'(src_w);
    end
  end

  always_comb begin
    xsel = (cmd.rd_sel == SEL_A || cmd.rd_sel == SEL_D) ? x0_r : x1_r;
    rowsel = (cmd.rd_sel == SEL_A || cmd.rd_sel == SEL_B) ? row0_r : row1_r;
    lin = (PW + 1)'(rowsel) + (PW + 1)'(xsel);
    rd_addr = AW'(lin);
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr && ({8'd0, sample_index} < DEPTH_C)) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mem[AW'(sample_index)][c] <= (c == 0) ? SB'(in_chan0) :
                                     (c == 1) ? SB'(in_chan1) : SB'(in_chan2);
      end
    end
    if (cmd.rd_issue) begin
      for (int c = 0; c < CHANNELS; c++) rd_r[c] <= mem[rd_addr][c];
    end
  end

  logic signed [FB+1:0] wdx1, wdx0, wdy1, wdy0;
  assign wdx1 = $signed({2'b00, dx_r});
  assign wdx0 = $signed((FB + 2)'(1) << FB) - wdx1;
  assign wdy1 = $signed({2'b00, dy_r});
  assign wdy0 = $signed((FB + 2)'(1) << FB) - wdy1;

  logic signed [HW-1:0]  h1 [CHANNELS];
  logic signed [HW-1:0]  h2 [CHANNELS];
  logic signed [FB+1:0]  l1 [CHANNELS];
  logic signed [FB+1:0]  l2 [CHANNELS];
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      h1[c] = HW'(t1_r[c] >>> FB);
      h2[c] = HW'(t2_r[c] >>> FB);
      l1[c] = $signed({2'b00, t1_r[c][FB-1:0]});
      l2[c] = $signed({2'b00, t2_r[c][FB-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd.rd_capture) nb_r[cmd.cap_sel[1:0]][c] <= $signed(rd_r[c]);
      if (cmd.blend_x) begin
        t1_r[c] <= T1W'(nb_r[0][c] * wdx0) + T1W'(nb_r[1][c] * wdx1);
        t2_r[c] <= T1W'(nb_r[2][c] * wdx0) + T1W'(nb_r[3][c] * wdx1);
      end
      if (cmd.blend_y) begin
        hi_r[c] <= ACW'(h1[c] * wdy0) + ACW'(h2[c] * wdy1);
        lo_r[c] <= ACW'(l1[c] * wdy0) + ACW'(l2[c] * wdy1);
      end
    end
  end

  logic signed [ACW-1:0] fin [NCH];
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      fin[c] = '0;
      if (c < CHANNELS) fin[c] = (hi_r[c] + (lo_r[c] >>> FB)) >>> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blend_fin) begin
      for (int c = 0; c < NCH; c++) res_r[c] <= CH_W'(fin[c]);
    end
    if (cmd.emit && err_r) begin
      for (int c = 0; c < NCH; c++) res_r[c] <= '0;
    end
  end

  assign out_chan0 = (cmd.emit && err_r) ? '0 : res_r[0];
  assign out_chan1 = (cmd.emit && err_r) ? '0 : res_r[1];
  assign out_chan2 = (cmd.emit && err_r) ? '0 : res_r[2];
  assign out_status = err_r;

endmodule

// ===== hdl/bilinear_map_resampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_map_resampler
// Bilinear resampling of a stored multi-channel source map.
// ----------------------------------------------------------------------------
// Store: accepted while idle, busy stays low. Interpolate: timing is set by
// two 38-step serial divisions and four store reads. Error results skip the
// divisions and reads; the geometry check sends them straight to output.
// One item at a time; out_valid pulses for one cycle, receiver cannot stall.
// Synchronous active-low reset restores default geometry;
// store contents are undefined until written.
module bilinear_map_resampler #(
  parameter int unsigned STORE_DEPTH   = bmr_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = bmr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CHANNELS      = bmr_pkg::CHANNELS_DEF,
  parameter int unsigned FRACTION_BITS = bmr_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic [bmr_pkg::IDX_W-1:0]        in_sample_index,
  input  logic [bmr_pkg::PT_W-1:0]         in_point_x,
  input  logic [bmr_pkg::PT_W-1:0]         in_point_y,
  input  logic signed [bmr_pkg::CH_W-1:0]  in_chan0,
  input  logic signed [bmr_pkg::CH_W-1:0]  in_chan1,
  input  logic signed [bmr_pkg::CH_W-1:0]  in_chan2,
  output logic                              out_valid,
  output logic signed [bmr_pkg::CH_W-1:0]  out_chan0,
  output logic signed [bmr_pkg::CH_W-1:0]  out_chan1,
  output logic signed [bmr_pkg::CH_W-1:0]  out_chan2,
  output logic                              out_status,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmr_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bmr_pkg::*;

  logic [SW_W-1:0] cfg_src_w_r, cfg_src_h_r;
  logic [TW_W-1:0] cfg_tgt_w_r, cfg_tgt_h_r;
  logic [1:0]      reg_sel;
  bmr_cmd_t        cmd;
  bmr_stat_t       stat;

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_src_w_r <= SW_W'(160);
      cfg_src_h_r <= SW_W'(120);
      cfg_tgt_w_r <= TW_W'(640);
      cfg_tgt_h_r <= TW_W'(480);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SRC_W: cfg_src_w_r <= pwdata[SW_W-1:0];
        REG_SRC_H: cfg_src_h_r <= pwdata[SW_W-1:0];
        REG_TGT_W: cfg_tgt_w_r <= pwdata[TW_W-1:0];
        REG_TGT_H: cfg_tgt_h_r <= pwdata[TW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SRC_W: prdata = 32'(cfg_src_w_r);
      REG_SRC_H: prdata = 32'(cfg_src_h_r);
      REG_TGT_W: prdata = 32'(cfg_tgt_w_r);
      REG_TGT_H: prdata = 32'(cfg_tgt_h_r);
      default:   prdata = '0;
    endcase
  end

  bmr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_operation),
    .busy(busy), .cmd(cmd), .stat(stat)
  );

  bmr_dpath #(
    .STORE_DEPTH(STORE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS),
    .CHANNELS(CHANNELS), .FRACTION_BITS(FRACTION_BITS)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n), .sample_index(in_sample_index), .point_x(in_point_x),
    .point_y(in_point_y), .in_chan0(in_chan0), .in_chan1(in_chan1),
    .in_chan2(in_chan2), .src_w(cfg_src_w_r), .src_h(cfg_src_h_r),
    .tgt_w(cfg_tgt_w_r), .tgt_h(cfg_tgt_h_r), .cmd(cmd), .stat(stat),
    .out_chan0(out_chan0), .out_chan1(out_chan1), .out_chan2(out_chan2),
    .out_status(out_status)
  );

  assign out_valid = cmd.emit;

endmodule

// ===== verif/bilinear_map_resampler_test.sv =====
// ----------------------------------------------------------------------------
// bilinear_map_resampler_test
// Self-checking bench for the bilinear map resampler. Stores source samples
// and requests interpolated points under a range of source and target
// geometries, valid and invalid, and checks each result against an in-bench
// bilinear predictor or directed expectation; reads only written store entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_map_resampler_test;
  import bmr_pkg::*;

  localparam int unsigned DEPTH = STORE_DEPTH_DEF;
  localparam longint ONE = 64'sd1 << FRACTION_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic                   op;
    logic [IDX_W-1:0]       idx;
    logic [PT_W-1:0]        px;
    logic [PT_W-1:0]        py;
    logic signed [CH_W-1:0] c0;
    logic signed [CH_W-1:0] c1;
    logic signed [CH_W-1:0] c2;
    logic                   typed;
    logic signed [CH_W-1:0] e0;
    logic signed [CH_W-1:0] e1;
    logic signed [CH_W-1:0] e2;
    logic                   est;
  } txn_t;

  typedef struct packed {
    logic signed [CH_W-1:0] c0;
    logic signed [CH_W-1:0] c1;
    logic signed [CH_W-1:0] c2;
    logic                   status;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = OP_STORE;
  logic [IDX_W-1:0] in_sample_index = '0;
  logic [PT_W-1:0] in_point_x = '0;
  logic [PT_W-1:0] in_point_y = '0;
  logic signed [CH_W-1:0] in_chan0 = '0;
  logic signed [CH_W-1:0] in_chan1 = '0;
  logic signed [CH_W-1:0] in_chan2 = '0;
  logic out_valid;
  logic signed [CH_W-1:0] out_chan0, out_chan1, out_chan2;
  logic out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #2 clk = ~clk;

  bilinear_map_resampler i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_sample_index(in_sample_index),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_chan0(in_chan0), .in_chan1(in_chan1), .in_chan2(in_chan2),
    .out_valid(out_valid), .out_chan0(out_chan0), .out_chan1(out_chan1),
    .out_chan2(out_chan2), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic signed [CH_W-1:0] src_mem [DEPTH][NCH];
  bit src_written [DEPTH];
  longint unsigned geo_sw = 160, geo_sh = 120, geo_tw = 640, geo_th = 480;

  point_t pending_points[$];
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic bit geometry_ok();
    return geo_sw >= 2 && geo_sh >= 2 && geo_tw >= 2 && geo_th >= 2 &&
           geo_sw * geo_sh <= DEPTH;
  endfunction

  function automatic bit point_ok(int unsigned x, int unsigned y);
    return geometry_ok() && x < geo_tw && y < geo_th;
  endfunction

  function automatic void split_axis(longint unsigned p, longint unsigned src,
                                     longint unsigned tgt, output longint unsigned lo,
                                     output longint unsigned hi, output longint frac);
    longint unsigned q;
    q = ((p * (src - 1)) << FRACTION_BITS_DEF) / (tgt - 1);
    lo = q >> FRACTION_BITS_DEF;
    frac = longint'(q & (ONE - 1));
    hi = (lo + 1 < src) ? lo + 1 : src - 1;
    if (lo > src - 1) begin
      lo = src - 1;
      hi = src - 1;
    end
  endfunction

  function automatic void corner_indices(int unsigned x, int unsigned y,
                                         output longint unsigned ix[4],
                                         output longint fx, output longint fy);
    longint unsigned x0, x1, y0, y1;
    split_axis(x, geo_sw, geo_tw, x0, x1, fx);
    split_axis(y, geo_sh, geo_th, y0, y1, fy);
    ix[0] = x0 + y0 * geo_sw;
    ix[1] = x1 + y0 * geo_sw;
    ix[2] = x0 + y1 * geo_sw;
    ix[3] = x1 + y1 * geo_sw;
  endfunction

  function automatic point_t resample_point(int unsigned x, int unsigned y);
    point_t r;
    longint unsigned ix[4];
    longint fx, fy, a, b, d, e, t1, t2, h1, h2, l1, l2, hi, lo, v;
    r = '0;
    if (!point_ok(x, y)) begin
      r.status = 1'b1;
      return r;
    end
    corner_indices(x, y, ix, fx, fy);
    for (int c = 0; c < NCH; c++) begin
      a = src_mem[ix[0]][c];
      b = src_mem[ix[1]][c];
      d = src_mem[ix[2]][c];
      e = src_mem[ix[3]][c];
      t1 = a * (ONE - fx) + b * fx;
      t2 = d * (ONE - fx) + e * fx;
      h1 = t1 >>> FRACTION_BITS_DEF;
      h2 = t2 >>> FRACTION_BITS_DEF;
      l1 = t1 - h1 * ONE;
      l2 = t2 - h2 * ONE;
      hi = h1 * (ONE - fy) + h2 * fy;
      lo = l1 * (ONE - fy) + l2 * fy;
      v = (hi + (lo >>> FRACTION_BITS_DEF)) >>> FRACTION_BITS_DEF;
      case (c)
        0: r.c0 = v[CH_W-1:0];
        1: r.c1 = v[CH_W-1:0];
        default: r.c2 = v[CH_W-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [CH_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return '0;
      3: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic txn_t store_txn(int unsigned idx);
    txn_t t;
    t = '0;
    t.op = OP_STORE;
    t.idx = IDX_W'(idx);
    t.px = PT_W'($urandom);
    t.py = PT_W'($urandom);
    t.c0 = rand_sample();
    t.c1 = rand_sample();
    t.c2 = rand_sample();
    return t;
  endfunction

  // Drives one transaction, holds it until accepted, and updates the predictor.
  task automatic send(txn_t t);
    point_t p;
    @(negedge clk);
    start <= 1'b1;
    in_operation <= t.op;
    in_sample_index <= t.idx;
    in_point_x <= t.px;
    in_point_y <= t.py;
    in_chan0 <= t.c0;
    in_chan1 <= t.c1;
    in_chan2 <= t.c2;
    do @(posedge clk); while (busy);
    if (t.op == OP_STORE) begin
      src_mem[t.idx][0] = t.c0;
      src_mem[t.idx][1] = t.c1;
      src_mem[t.idx][2] = t.c2;
      src_written[t.idx] = 1'b1;
    end else if (t.typed) begin
      p.c0 = t.e0;
      p.c1 = t.e1;
      p.c2 = t.e2;
      p.status = t.est;
      pending_points.push_back(p);
    end else begin
      pending_points.push_back(resample_point(t.px, t.py));
    end
  endtask

  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 19))
      0: n = $urandom_range(20, 60);
      1, 2: n = $urandom_range(4, 12);
      3, 4, 5, 6, 7, 8, 9: n = $urandom_range(1, 3);
      default: n = 0;
    endcase
    repeat (n) @(negedge clk) start <= 1'b0;
  endtask

  // Writes unwritten store entries a valid point reads, then requests it.
  task automatic interpolate(int unsigned x, int unsigned y);
    longint unsigned ix[4];
    longint fx, fy;
    txn_t t;
    if (point_ok(x, y)) begin
      corner_indices(x, y, ix, fx, fy);
      for (int k = 0; k < 4; k++) begin
        if (!src_written[ix[k]]) begin
          send(store_txn(ix[k]));
          idle_gap();
        end
      end
    end
    t = store_txn(0);
    t.op = OP_INTERP;
    t.idx = IDX_W'($urandom);
    t.px = PT_W'(x);
    t.py = PT_W'(y);
    send(t);
    idle_gap();
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] sel, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({sel, 2'b00});
    pwdata <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      REG_SRC_W: geo_sw = value & 32'h7FF;
      REG_SRC_H: geo_sh = value & 32'h7FF;
      REG_TGT_W: geo_tw = value & 32'hFFF;
      default:   geo_th = value & 32'hFFF;
    endcase
  endtask

  always @(posedge clk) begin
    point_t exp_p;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %0d %0d %0d status %0b",
                   out_chan0, out_chan1, out_chan2, out_status);
      end else begin
        exp_p = pending_points.pop_front();
        if (out_chan0 !== exp_p.c0 || out_chan1 !== exp_p.c1 ||
            out_chan2 !== exp_p.c2 || out_status !== exp_p.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected %0d %0d %0d status %0b, got %0d %0d %0d status %0b",
                     exp_p.c0, exp_p.c1, exp_p.c2, exp_p.status,
                     out_chan0, out_chan1, out_chan2, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bilinear_map_resampler verification failed");
      $finish;
    end
  end

  txn_t directed [$];
  int unsigned geo_list [14][4] = '{
    '{2, 2, 2048, 2048}, '{1024, 32, 3, 5}, '{7, 5, 13, 9}, '{2, 2, 2, 2},
    '{181, 181, 2047, 1500}, '{182, 181, 64, 64}, '{1, 5, 8, 8},
    '{5, 0, 8, 8}, '{2047, 2047, 4095, 4095}, '{4, 4, 1, 8}, '{4, 4, 8, 0},
    '{300, 100, 17, 11}, '{1024, 2, 2048, 3}, '{2, 1024, 2, 2048}
  };

  function automatic txn_t mk(logic op, int unsigned idx, int unsigned x, int unsigned y,
                              int c0, int c1, int c2, bit typed,
                              int e0, int e1, int e2, bit est);
    txn_t t;
    t.op = op; t.idx = IDX_W'(idx); t.px = PT_W'(x); t.py = PT_W'(y);
    t.c0 = CH_W'(c0); t.c1 = CH_W'(c1); t.c2 = CH_W'(c2);
    t.typed = typed; t.e0 = CH_W'(e0); t.e1 = CH_W'(e1); t.e2 = CH_W'(e2);
    t.est = est;
    return t;
  endfunction

  initial begin
    int unsigned x, y, xmax, ymax;
    directed = '{
      mk(OP_INTERP, 0, 640, 0, 0, 0, 0, 1, 0, 0, 0, 1),
      mk(OP_INTERP, 0, 0, 480, 0, 0, 0, 1, 0, 0, 0, 1),
      mk(OP_INTERP, 32767, 2047, 2047, -1, -1, -1, 1, 0, 0, 0, 1),
      mk(OP_STORE, 0, 0, 0, 32767, -32768, 21845, 0, 0, 0, 0, 0),
      mk(OP_STORE, 1, 2047, 2047, -1, 0, -21846, 0, 0, 0, 0, 0),
      mk(OP_STORE, 160, 0, 0, 100, -100, 7, 0, 0, 0, 0, 0),
      mk(OP_STORE, 161, 0, 0, -32768, 32767, -1, 0, 0, 0, 0, 0),
      mk(OP_STORE, 32767, 1365, 682, -32768, -32768, 32767, 0, 0, 0, 0, 0),
      mk(OP_INTERP, 0, 0, 0, 0, 0, 0, 1, 32767, -32768, 21845, 0),
      mk(OP_STORE, 19199, 0, 0, -12345, 2, 32767, 0, 0, 0, 0, 0),
      mk(OP_INTERP, 0, 639, 479, 0, 0, 0, 1, -12345, 2, 32767, 0),
      mk(OP_INTERP, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_INTERP, 0, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_INTERP, 0, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0)
    };
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed[i]) begin
      send(directed[i]);
      idle_gap();
    end
    drain();

    foreach (geo_list[g]) begin
      reg_write(REG_SRC_W, geo_list[g][0]);
      reg_write(REG_SRC_H, geo_list[g][1]);
      reg_write(REG_TGT_W, geo_list[g][2]);
      reg_write(REG_TGT_H, geo_list[g][3]);
      xmax = (geo_tw >= 1 && geo_tw <= 2048) ? geo_tw - 1 : 2047;
      ymax = (geo_th >= 1 && geo_th <= 2048) ? geo_th - 1 : 2047;
      if (geo_tw == 0) xmax = 0;
      if (geo_th == 0) ymax = 0;
      for (int n = 0; n < 20; n++) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            send(store_txn($urandom_range(0, DEPTH - 1)));
            idle_gap();
          end
          2, 3: interpolate($urandom_range(0, 2047), $urandom_range(0, 2047));
          4, 5, 6: interpolate($urandom_range(0, 1) ? xmax : 0,
                               $urandom_range(0, 1) ? ymax : 0);
          default: begin
            x = $urandom_range(0, xmax);
            y = $urandom_range(0, ymax);
            interpolate(x, y);
          end
        endcase
      end
      drain();
    end

    if (mismatches == 0)
      $display("bilinear_map_resampler verification clean");
    else
      $display("bilinear_map_resampler verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bmr_pkg.sv
hdl/bmr_ctrl.sv
hdl/bmr_div.sv
hdl/bmr_dpath.sv
hdl/bilinear_map_resampler.sv
verif/bilinear_map_resampler_test.sv
